// ===== rtl/safs_pkg.sv =====
// ----------------------------------------------------------------------------
// safs_pkg
// Shared types and constants for the slot allocator with a LIFO free stack.
// ----------------------------------------------------------------------------
package safs_pkg;

  localparam int SLOTS    = 256;
  localparam int IDX_W    = $clog2(SLOTS);
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int HANDLE_W = 32;
  localparam int LIMIT_W  = 9;

  localparam logic [CNT_W-1:0]   SLOTS_CNT   = CNT_W'(SLOTS);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);

  typedef enum logic [0:0] {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_IGNORED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SHRINK,
    S_DONE
  } state_t;

  // occupancy bit commands and read address
  typedef struct packed {
    logic             set;
    logic             clr;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
  } occ_cmd_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] extent;
    logic [CNT_W-1:0] free_entries;
  } result_t;

endpackage

// ===== rtl/safs_ram.sv =====
// ----------------------------------------------------------------------------
// safs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module safs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/safs_occ.sv =====
// ----------------------------------------------------------------------------
// safs_occ
// Slot occupancy bits: one flag per slot, cleared at reset, one read port.
// ----------------------------------------------------------------------------
module safs_occ (
  input  logic               clk,
  input  logic               rst,
  input  safs_pkg::occ_cmd_t cmd,
  output logic               rd_used
);
  import safs_pkg::*;

  logic [SLOTS-1:0] occ;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      if (cmd.set) begin
        occ[cmd.wr_idx] <= 1'b1;
      end
      if (cmd.clr) begin
        occ[cmd.wr_idx] <= 1'b0;
      end
    end
  end

  assign rd_used = occ[cmd.rd_idx];

endmodule

// ===== rtl/safs_ctrl.sv =====
// ----------------------------------------------------------------------------
// safs_ctrl
// Sequencer: decodes a request, pops or pushes the free stack, and steps the
// extent down one slot per cycle after removal of the last used slot.
// ----------------------------------------------------------------------------
module safs_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_action,
  input  logic [safs_pkg::HANDLE_W-1:0]   in_handle,
  input  logic [safs_pkg::IDX_W-1:0]      in_index,
  input  logic                            cfg_we,
  input  logic [safs_pkg::LIMIT_W-1:0]    cfg_data,
  output safs_pkg::occ_cmd_t              occ_cmd,
  input  logic                            occ_used,
  output logic                            stk_we,
  output logic [safs_pkg::IDX_W-1:0]      stk_waddr,
  output logic [safs_pkg::IDX_W-1:0]      stk_wdata,
  output logic [safs_pkg::IDX_W-1:0]      stk_raddr,
  input  logic [safs_pkg::IDX_W-1:0]      stk_rdata,
  output logic                            res_valid,
  input  logic                            res_ready,
  output safs_pkg::result_t               res
);
  import safs_pkg::*;

  state_t             state, state_next;
  logic [CNT_W-1:0]   free_depth, free_depth_next;
  logic [CNT_W-1:0]   high_water, high_water_next;
  logic [LIMIT_W-1:0] slot_limit;
  status_t            status, status_next;
  logic [IDX_W-1:0]   slot, slot_next;

  logic [CNT_W-1:0]   lim;
  logic [CNT_W-1:0]   depth_m1;
  logic [CNT_W-1:0]   hw_m1;
  logic [CNT_W-1:0]   pop_ext;

  // values above the table depth act as the depth
  assign lim      = (slot_limit > LIMIT_W'(SLOTS)) ? SLOTS_CNT : CNT_W'(slot_limit);
  assign depth_m1 = free_depth - CNT_W'(1);
  assign hw_m1    = high_water - CNT_W'(1);
  assign pop_ext  = {1'b0, stk_rdata} + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_depth <= '0;
      high_water <= '0;
      slot_limit <= LIMIT_RESET;
      status     <= ST_IGNORED;
      slot       <= '0;
    end else begin
      state      <= state_next;
      free_depth <= free_depth_next;
      high_water <= high_water_next;
      status     <= status_next;
      slot       <= slot_next;
      if (cfg_we) begin
        slot_limit <= cfg_data;
      end
    end
  end

  always_comb begin
    state_next      = state;
    free_depth_next = free_depth;
    high_water_next = high_water;
    status_next     = status;
    slot_next       = slot;
    in_ready        = 1'b0;
    res_valid       = 1'b0;
    occ_cmd.set     = 1'b0;
    occ_cmd.clr     = 1'b0;
    occ_cmd.wr_idx  = in_index;
    occ_cmd.rd_idx  = in_index;
    stk_we          = 1'b0;
    stk_waddr       = free_depth[IDX_W-1:0];
    stk_wdata       = in_index;
    stk_raddr       = depth_m1[IDX_W-1:0];

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next  = S_DONE;
          status_next = ST_IGNORED;
          slot_next   = '0;
          if (in_action == ACT_INSERT) begin
            if (in_handle == '0) begin
              status_next = ST_IGNORED;
            end else if (free_depth != '0) begin
              // stack read issued now, data next cycle
              free_depth_next = depth_m1;
              state_next      = S_POP;
            end else if (high_water < lim) begin
              occ_cmd.set     = 1'b1;
              occ_cmd.wr_idx  = high_water[IDX_W-1:0];
              high_water_next = high_water + CNT_W'(1);
              status_next     = ST_INSERTED;
              slot_next       = high_water[IDX_W-1:0];
            end else begin
              status_next = ST_FULL;
            end
          end else begin
            if (({1'b0, in_index} < lim) && occ_used) begin
              occ_cmd.clr = 1'b1;
              status_next = ST_REMOVED;
              slot_next   = in_index;
              if (free_depth < SLOTS_CNT) begin
                stk_we          = 1'b1;
                free_depth_next = free_depth + CNT_W'(1);
              end
              if ((high_water != '0) && ({1'b0, in_index} == hw_m1)) begin
                high_water_next = {1'b0, in_index};
                state_next      = S_SHRINK;
              end
            end
          end
        end
      end

      S_POP: begin
        occ_cmd.set    = 1'b1;
        occ_cmd.wr_idx = stk_rdata;
        status_next    = ST_INSERTED;
        slot_next      = stk_rdata;
        if ({1'b0, stk_rdata} >= high_water) begin
          high_water_next = pop_ext;
        end
        state_next = S_DONE;
      end

      // walk the extent down past trailing empty slots
      S_SHRINK: begin
        occ_cmd.rd_idx = hw_m1[IDX_W-1:0];
        if ((high_water == '0) || occ_used) begin
          state_next = S_DONE;
        end else begin
          high_water_next = hw_m1;
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign res.status       = status;
  assign res.slot         = slot;
  assign res.extent       = high_water;
  assign res.free_entries = free_depth;

endmodule

// ===== rtl/slot_allocator_free_stack.sv =====
// ----------------------------------------------------------------------------
// slot_allocator_free_stack
// Slot allocator with a LIFO free stack and an occupancy-tracked extent.
// ----------------------------------------------------------------------------
// sequence: an accepted word passes the done state and the output register to
//   give its result word; a pop of the free stack goes through the pop state
//   first, and a remove of the last used slot walks the extent down past the trailing empty slots
// throughput: one word at a time; the next word is taken once the result is
//   handed to the output register, later for a pop or an extent walk over the
//   occupancy bits
// reset: all slots empty, free stack empty, extent 0, slot limit 256
// ----------------------------------------------------------------------------
module slot_allocator_free_stack (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // handle[31:0], slot_index[39:32]
  input  logic [0:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // slot[7:0], extent[16:8], free_entries[25:17]
  output logic [1:0]  m_tuser,   // status
  input  logic        cfg_we,
  input  logic [8:0]  cfg_data   // slot_limit
);
  import safs_pkg::*;

  occ_cmd_t         occ_cmd;
  logic             occ_used;
  logic             stk_we;
  logic [IDX_W-1:0] stk_waddr;
  logic [IDX_W-1:0] stk_wdata;
  logic [IDX_W-1:0] stk_raddr;
  logic [IDX_W-1:0] stk_rdata;
  logic             res_valid;
  logic             res_ready;
  result_t          res;
  result_t          out_res;

  safs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (s_tuser[0]),
    .in_handle (s_tdata[HANDLE_W-1:0]),
    .in_index  (s_tdata[HANDLE_W+IDX_W-1:HANDLE_W]),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .occ_cmd   (occ_cmd),
    .occ_used  (occ_used),
    .stk_we    (stk_we),
    .stk_waddr (stk_waddr),
    .stk_wdata (stk_wdata),
    .stk_raddr (stk_raddr),
    .stk_rdata (stk_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  safs_occ u_occ (
    .clk     (clk),
    .rst     (rst),
    .cmd     (occ_cmd),
    .rd_used (occ_used)
  );

  safs_ram #(
    .WIDTH (IDX_W),
    .DEPTH (SLOTS)
  ) u_free_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // output register parts the result side from the sequencer
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {6'd0, out_res.free_entries, out_res.extent, out_res.slot};
  assign m_tuser = out_res.status;

endmodule
